/* rtl/keyboard_report_frame_splitter_defines.svh */
// assertion macros used by the checker file
`ifndef KEYBOARD_REPORT_FRAME_SPLITTER_DEFINES_SVH
`define KEYBOARD_REPORT_FRAME_SPLITTER_DEFINES_SVH

// implication checked at every clock edge out of reset
`define KRFS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyboard report frame splitter check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define KRFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyboard report frame splitter check failed");

// condition that must never hold
`define KRFS_ASSERT_NEVER(label, cond) \
  `KRFS_ASSERT_IMPL(label, 1'b1, !(cond))

`endif

/* rtl/krfs_pkg.sv */
// package with types, codes and report decode for the frame splitter
package krfs_pkg;

  localparam int FRAME_MAX_DEF = 255;

  localparam logic [7:0] SYNC_BYTE = 8'h57;
  localparam logic [7:0] TAG_A     = 8'h39;
  localparam logic [7:0] TAG_B     = 8'h4A;
  localparam logic [7:0] TAG_C     = 8'h5B;
  localparam logic [7:0] TAG_D     = 8'h6C;

  localparam logic [7:0] TYPE_KBD      = 8'h05;
  localparam logic [7:0] TYPE_CONSUMER = 8'h06;
  localparam logic [7:0] TYPE_MOUSE    = 8'h02;
  localparam logic [7:0] TYPE_TOUCH    = 8'h19;
  localparam logic [7:0] TYPE_VEND16   = 8'h22;
  localparam logic [7:0] TYPE_VEND32   = 8'h23;
  localparam logic [7:0] TYPE_TAIL_A   = 8'h24;
  localparam logic [7:0] TYPE_TAIL_B   = 8'h26;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_GAP  = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    RT_DROP        = 4'd0,
    RT_KBD_INPUT   = 4'd1,
    RT_KBD_CACHE   = 4'd2,
    RT_CONS_INPUT  = 4'd3,
    RT_CONS_CACHE  = 4'd4,
    RT_MOUSE       = 4'd5,
    RT_TOUCH       = 4'd6,
    RT_VEND16      = 4'd7,
    RT_VEND32      = 4'd8,
    RT_TAIL        = 4'd9
  } route_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_SYNC  = 3'd2,
    ST_NULL      = 3'd3,
    ST_BAD_TAG   = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] frame_length;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t frame_status;
    logic    report_end;
    logic    report_start;
    route_t  route;
  } res_flags_t;

  typedef struct packed {
    logic       known;
    logic       tail;
    logic [5:0] len;
    route_t     rt_open;
    route_t     rt_closed;
  } type_info_t;

  function automatic type_info_t decode_type(input logic [7:0] b);
    type_info_t ti;
    ti = '{known: 1'b1, tail: 1'b0, len: 6'd0, rt_open: RT_DROP, rt_closed: RT_DROP};
    unique case (b)
      TYPE_KBD:      begin ti.len = 6'd9;  ti.rt_open = RT_KBD_INPUT;
                           ti.rt_closed = RT_KBD_CACHE; end
      TYPE_CONSUMER: begin ti.len = 6'd5;  ti.rt_open = RT_CONS_INPUT;
                           ti.rt_closed = RT_CONS_CACHE; end
      TYPE_MOUSE:    begin ti.len = 6'd8;  ti.rt_open = RT_MOUSE;  ti.rt_closed = RT_MOUSE; end
      TYPE_TOUCH:    begin ti.len = 6'd21; ti.rt_open = RT_TOUCH;  ti.rt_closed = RT_TOUCH; end
      TYPE_VEND16:   begin ti.len = 6'd16; ti.rt_open = RT_VEND16; ti.rt_closed = RT_VEND16; end
      TYPE_VEND32:   begin ti.len = 6'd32; ti.rt_open = RT_VEND32; ti.rt_closed = RT_VEND32; end
      TYPE_TAIL_A,
      TYPE_TAIL_B:   begin ti.tail = 1'b1; ti.rt_open = RT_TAIL;   ti.rt_closed = RT_TAIL; end
      default:       ti.known = 1'b0;
    endcase
    return ti;
  endfunction

  function automatic logic tag_ok(input logic [7:0] b);
    return (b == TAG_A) || (b == TAG_B) || (b == TAG_C) || (b == TAG_D);
  endfunction

endpackage

/* rtl/krfs_parser.sv */
// frame parse state and per-byte classification
module krfs_parser import krfs_pkg::*; #(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,        // item moves to the result register this cycle
  input  in_item_t   item,
  input  logic       panel_open,
  output res_flags_t res,
  output logic       frame_end
);

  localparam logic [7:0] LIM_CAP = (FRAME_MAX >= 256) ? 8'hFF : 8'(FRAME_MAX);

  logic [7:0] pos_r,    pos_nxt;
  logic [5:0] rem_r,    rem_nxt;
  route_t     route_r,  route_nxt;
  status_t    status_r, status_nxt;
  phase_t     phase_r,  phase_nxt;

  logic [7:0] lim;
  logic [7:0] left;
  logic [8:0] pos_inc;
  type_info_t ti;
  logic [7:0] len;
  route_t     rt_sel;

  always_comb begin
    lim     = (item.frame_length < LIM_CAP) ? item.frame_length : LIM_CAP;
    left    = lim - pos_r;
    pos_inc = {1'b0, pos_r} + 9'd1;
    ti      = decode_type(item.data_byte);
    len     = ti.tail ? left : {2'b00, ti.len};
    rt_sel  = panel_open ? ti.rt_open : ti.rt_closed;

    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    route_nxt  = route_r;
    status_nxt = status_r;
    phase_nxt  = phase_r;
    res.route        = RT_DROP;
    res.report_start = 1'b0;
    res.report_end   = 1'b0;

    if (pos_r < lim) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (pos_r == 8'd0) begin
            if (lim < 8'd3) begin
              status_nxt = ST_SHORT;
              phase_nxt  = PH_DONE;
            end else if (item.data_byte != SYNC_BYTE) begin
              status_nxt = ST_BAD_SYNC;
              phase_nxt  = PH_DONE;
            end
          end else if (pos_r == 8'd2) begin
            if (item.data_byte == 8'd0) begin
              status_nxt = ST_NULL;
              phase_nxt  = PH_DONE;
            end else if (!tag_ok(item.data_byte)) begin
              status_nxt = ST_BAD_TAG;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_GAP;
            end
          end
        end
        PH_GAP: begin
          if (left < 8'd3) begin
            status_nxt = ST_TRUNCATED;
            phase_nxt  = PH_DONE;
          end else if (!ti.known) begin
            phase_nxt = PH_DONE;      // unknown type ends parsing, status stays ok
          end else if (len > left) begin
            status_nxt = ST_TRUNCATED;
            phase_nxt  = PH_DONE;
          end else begin
            res.route        = rt_sel;
            res.report_start = 1'b1;
            route_nxt        = rt_sel;
            rem_nxt          = ti.tail ? 6'd0 : (ti.len - 6'd1);
            phase_nxt        = PH_BODY;
          end
        end
        PH_BODY: begin
          res.route = route_r;
          if (route_r == RT_TAIL) begin
            if (left == 8'd1) begin
              res.report_end = 1'b1;
              phase_nxt      = PH_GAP;
            end
          end else begin
            if (rem_r > 6'd0) rem_nxt = rem_r - 6'd1;
            if (rem_r <= 6'd1) begin
              res.report_end = 1'b1;
              phase_nxt      = PH_GAP;
            end
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end

    res.frame_status = status_nxt;
    frame_end        = (pos_inc >= {1'b0, item.frame_length});

    if (frame_end) begin
      pos_nxt    = 8'd0;
      rem_nxt    = 6'd0;
      route_nxt  = RT_DROP;
      status_nxt = ST_OK;
      phase_nxt  = PH_HEAD;
    end else begin
      pos_nxt = pos_inc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 8'd0;
      rem_r    <= 6'd0;
      route_r  <= RT_DROP;
      status_r <= ST_OK;
      phase_r  <= PH_HEAD;
    end else if (step) begin
      pos_r    <= pos_nxt;
      rem_r    <= rem_nxt;
      route_r  <= route_nxt;
      status_r <= status_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

/* rtl/keyboard_report_frame_splitter.sv */
// top level of the keyboard report frame splitter
// Splits a received frame, one byte per item, into keyboard, consumer, mouse,
// touch and vendor reports and tags every byte with a route; the frame status
// is final on the byte that carries out_tlast. Throughput is one byte per
// clock while out_tready is not held low: a byte is accepted into the input
// register, the parser classifies it against the frame state in a single pass
// and the result lands in the output register, where out_tvalid rises and it
// waits until taken. The only loop is the parse state update (position
// counter and report countdown). The input register keeps taking bytes while
// a result waits, until both stages are full.
// panel_open is sampled when a report's type byte is parsed; write it only
// while no byte is in flight. Bytes past FRAME_MAX in a longer frame are
// passed through with route drop.
module keyboard_report_frame_splitter import krfs_pkg::*; #(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,      // panel_open
  // byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [7:0] data_byte, [15:8] frame_length
  // routed byte output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // [7:0] byte_out
  output logic [8:0]  out_tuser,     // [3:0] route, [4] report_start,
                                     // [5] report_end, [8:6] frame_status
  output logic        out_tlast      // frame_end
);

  // configuration register
  logic panel_open_r;

  // input register
  logic     in_valid_r;
  in_item_t in_item_r;

  // result register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  res_flags_t out_flags_r;
  logic       out_last_r;

  res_flags_t res;
  logic       frame_end;
  logic       advance;   // input register content moves to the result register

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_open_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      panel_open_r <= cfg_data;
    end
  end

  // result stage frees up when empty or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item_t'(in_tdata);
    end
  end

  krfs_parser #(
    .FRAME_MAX (FRAME_MAX)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (in_item_r),
    .panel_open (panel_open_r),
    .res        (res),
    .frame_end  (frame_end)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  // payload follows the parser only when a byte actually moves
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r  <= in_item_r.data_byte;
      out_flags_r <= res;
      out_last_r  <= frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_flags_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/kbrfs_checker.sv */
// port-level checker for the frame splitter, bound to the top level
`include "keyboard_report_frame_splitter_defines.svh"

module kbrfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [8:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result holds
  `KRFS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // a routed byte only ever appears in a frame with ok status
  `KRFS_ASSERT_IMPL(a_route_ok, out_tvalid && (out_tuser[3:0] != 4'd0), out_tuser[8:6] == 3'd0)

  // a report start carries a real route and is never also its end
  `KRFS_ASSERT_IMPL(a_start_route, out_tvalid && out_tuser[4], (out_tuser[3:0] != 4'd0) && !out_tuser[5])

  // route and status stay within their code ranges
  `KRFS_ASSERT_NEVER(a_codes, out_tvalid && ((out_tuser[3:0] > 4'd9) || (out_tuser[8:6] > 3'd5)))

  // input only stalls behind a waiting result
  `KRFS_ASSERT_IMPL(a_stall_cause, in_tvalid && !in_tready, out_tvalid && !out_tready)

endmodule

bind keyboard_report_frame_splitter kbrfs_checker u_kbrfs_checker (.*);

/* tb/testbench.sv */
// self-checking testbench for the keyboard report frame splitter
`timescale 1ns / 1ps

module testbench;
  import krfs_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int LATENCY      = 2;

  // one routed byte as it should leave the block
  typedef struct packed {
    logic [7:0] byte_out;
    route_t     route;
    logic       rstart;
    logic       rend;
    status_t    status;
    logic       fend;
  } routed_t;

  // result fields typed into the directed table; on = 0 leaves the row to the predictor
  typedef struct packed {
    logic    on;
    route_t  route;
    logic    rstart;
    logic    rend;
    status_t status;
    logic    fend;
  } pinned_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] flen;
    pinned_t    pin;
  } row_t;

  localparam pinned_t NO_PIN = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [8:0]  out_tuser;
  logic        out_tlast;

  keyboard_report_frame_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // predictor copy of the parse state, reset values
  logic [7:0] pos_r    = '0;
  logic [5:0] remain_r = '0;
  route_t     route_r  = RT_DROP;
  status_t    status_r = ST_OK;
  phase_t     phase_r  = PH_HEAD;
  logic       panel_r  = 1'b0;

  routed_t routed_q[$];   // routed bytes still owed by the block
  pinned_t pinned_q[$];   // typed-in fields, one per offered byte
  row_t    rows[$];

  int  mismatches = 0;
  int  bytes_in = 0;      // bytes accepted by the block
  int  bytes_sent = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;      // no idling on either side when set

  // error ends parsing; rest of the frame is dropped
  function automatic void give_up(input status_t s);
    status_r = s;
    phase_r = PH_DONE;
  endfunction

  // classify one byte against the frame state and advance that state
  function automatic routed_t split_byte(input logic [7:0] b, input logic [7:0] flen);
    routed_t r;
    int      lim;
    int      left;
    int      rlen;
    route_t  rt;
    logic    tail;
    lim = (flen < FRAME_MAX_DEF) ? flen : FRAME_MAX_DEF;
    r = '{byte_out: b, route: RT_DROP, rstart: 1'b0, rend: 1'b0, status: ST_OK, fend: 1'b0};
    if (pos_r < lim) begin
      left = lim - pos_r;
      case (phase_r)
        PH_HEAD: begin
          if (pos_r == 0) begin
            if (lim < 3) give_up(ST_SHORT);
            else if (b != SYNC_BYTE) give_up(ST_BAD_SYNC);
          end else if (pos_r == 2) begin
            if (b == 8'h00) give_up(ST_NULL);
            else if (!(b == TAG_A || b == TAG_B || b == TAG_C || b == TAG_D))
              give_up(ST_BAD_TAG);
            else phase_r = PH_GAP;
          end
        end
        PH_GAP: begin
          rlen = 0;
          rt = RT_DROP;
          tail = 1'b0;
          if (left < 3) begin
            give_up(ST_TRUNCATED);
          end else begin
            case (b)
              TYPE_KBD:      begin rlen = 9;  rt = panel_r ? RT_KBD_INPUT : RT_KBD_CACHE; end
              TYPE_CONSUMER: begin rlen = 5;  rt = panel_r ? RT_CONS_INPUT : RT_CONS_CACHE; end
              TYPE_MOUSE:    begin rlen = 8;  rt = RT_MOUSE; end
              TYPE_TOUCH:    begin rlen = 21; rt = RT_TOUCH; end
              TYPE_VEND16:   begin rlen = 16; rt = RT_VEND16; end
              TYPE_VEND32:   begin rlen = 32; rt = RT_VEND32; end
              TYPE_TAIL_A, TYPE_TAIL_B: begin rlen = left; rt = RT_TAIL; tail = 1'b1; end
              default: ;
            endcase
            if (rlen == 0) begin
              phase_r = PH_DONE;      // unknown type: status stays ok
            end else if (rlen > left) begin
              give_up(ST_TRUNCATED);
            end else begin
              r.route = rt;
              r.rstart = 1'b1;
              route_r = rt;
              remain_r = tail ? 6'd0 : 6'(rlen - 1);
              phase_r = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          r.route = route_r;
          if (route_r == RT_TAIL) begin
            // tail report runs to the last parsed byte
            if (left == 1) begin
              r.rend = 1'b1;
              phase_r = PH_GAP;
            end
          end else begin
            if (remain_r > 0) remain_r = remain_r - 6'd1;
            if (remain_r == 0) begin
              r.rend = 1'b1;
              phase_r = PH_GAP;
            end
          end
        end
        default: ;
      endcase
    end
    r.fend = (int'(pos_r) + 1 >= int'(flen));
    r.status = status_r;
    if (r.fend) begin
      pos_r = '0;
      remain_r = '0;
      route_r = RT_DROP;
      status_r = ST_OK;
      phase_r = PH_HEAD;
    end else begin
      pos_r = pos_r + 8'd1;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_tag();
    case ($urandom_range(0, 3))
      0: return TAG_A;
      1: return TAG_B;
      2: return TAG_C;
      default: return TAG_D;
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // offer one byte, with an occasional idle burst before it
  task automatic send_byte(input logic [7:0] b, input logic [7:0] flen, input pinned_t pin);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    pinned_q.push_back(pin);
    in_tvalid <= 1'b1;
    in_tdata <= {flen, b};
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // stop offering, wait until every routed byte is out, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (routed_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_panel(input logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    panel_r = v;
  endtask

  task automatic add_row(input logic [7:0] b, input logic [7:0] flen, input logic on,
                         input route_t rt, input logic rs, input logic re,
                         input status_t st, input logic fe);
    row_t row;
    row.b = b;
    row.flen = flen;
    row.pin = '{on: on, route: rt, rstart: rs, rend: re, status: st, fend: fe};
    rows.push_back(row);
  endtask

  // well-formed frame: good header, a few reports, sometimes a ragged end or a cut
  task automatic send_good_frame();
    logic [7:0] fq[$];
    logic [7:0] t;
    int         rlen;
    int         flen;
    int         nrep;
    logic       big;
    logic       ended;
    big = ($urandom_range(0, 24) == 0);
    nrep = big ? 64 : $urandom_range(0, 4);
    ended = 1'b0;
    fq.push_back(SYNC_BYTE);
    fq.push_back(8'($urandom_range(0, 255)));
    fq.push_back(pick_tag());
    for (int k = 0; k < nrep && !ended; k++) begin
      case ($urandom_range(0, 7))
        0: begin t = TYPE_KBD;      rlen = 9;  end
        1: begin t = TYPE_CONSUMER; rlen = 5;  end
        2: begin t = TYPE_MOUSE;    rlen = 8;  end
        3: begin t = TYPE_TOUCH;    rlen = 21; end
        4: begin t = TYPE_VEND16;   rlen = 16; end
        5: begin t = TYPE_VEND32;   rlen = 32; end
        6: begin t = TYPE_TAIL_A;   rlen = 0;  end
        default: begin t = TYPE_TAIL_B; rlen = 0; end
      endcase
      if (rlen == 0) begin
        rlen = $urandom_range(3, 12);
        ended = 1'b1;
      end
      if (fq.size() + rlen > FRAME_MAX_DEF) break;
      fq.push_back(t);
      repeat (rlen - 1) fq.push_back(8'($urandom_range(0, 255)));
    end
    if (big) begin
      // pad to the longest frame, tail report if there is room
      if (!ended && FRAME_MAX_DEF - fq.size() >= 3) fq.push_back(TYPE_TAIL_B);
      while (fq.size() < FRAME_MAX_DEF) fq.push_back(8'($urandom_range(0, 255)));
    end else if (!ended) begin
      case ($urandom_range(0, 5))
        0: repeat ($urandom_range(3, 5)) fq.push_back(8'($urandom_range(0, 255)));
        1: repeat ($urandom_range(1, 2)) fq.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    flen = fq.size();
    // cut the frame short at a random length, which may end it inside a report
    if (flen > 4 && $urandom_range(0, 7) == 0) flen = $urandom_range(3, flen - 1);
    for (int i = 0; i < flen; i++) send_byte(fq[i], 8'(flen), NO_PIN);
  endtask

  // random bytes, odd lengths, sometimes a length that changes mid-frame
  task automatic send_noise();
    int         flen;
    int         nb;
    logic       shifty;
    logic [7:0] b;
    logic [7:0] l;
    flen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
    nb = (flen == 0) ? 1 : flen;
    shifty = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < nb; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 0 && $urandom_range(0, 1) == 0) b = SYNC_BYTE;
      if (i == 2 && $urandom_range(0, 1) == 0)
        b = ($urandom_range(0, 3) == 0) ? 8'h00 : pick_tag();
      l = 8'(flen);
      // last byte with length 1 always closes the frame, keeping later frames aligned
      if (shifty) l = (i == nb - 1) ? 8'd1 : 8'($urandom_range(0, 8));
      send_byte(b, l, NO_PIN);
    end
  endtask

  task automatic random_frames(input int n_items);
    int stop_at;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 4) != 0) send_good_frame();
      else send_noise();
    end
  endtask

  // accepted byte: predict its routing, typed-in fields override where given
  always @(posedge clk) begin : in_mon
    routed_t r;
    pinned_t pin;
    if (rst_n && in_tvalid && in_tready) begin
      r = split_byte(in_tdata[7:0], in_tdata[15:8]);
      pin = pinned_q.pop_front();
      if (pin.on) begin
        r.route = pin.route;
        r.rstart = pin.rstart;
        r.rend = pin.rend;
        r.status = pin.status;
        r.fend = pin.fend;
      end
      routed_q.push_back(r);
      bytes_in++;
    end
  end

  // routed byte out: compare with the oldest prediction
  always @(posedge clk) begin : out_mon
    routed_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (routed_q.size() == 0) begin
        $display("%0t: item with none expected, expected none actual byte %0d tuser %0d last %0d",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = routed_q.pop_front();
        check_field("byte_out", want.byte_out, out_tdata);
        check_field("route", want.route, out_tuser[3:0]);
        check_field("report_start", want.rstart, out_tuser[4]);
        check_field("report_end", want.rend, out_tuser[5]);
        check_field("frame_status", want.status, out_tuser[8:6]);
        check_field("frame_end", want.fend, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off so the input backs up
  initial begin : sink
    bit held;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held && bytes_in >= 200) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : stim
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_panel(1'b0);

    // one-byte frame: too short
    add_row(8'hFF, 8'd1, 1'b1, RT_DROP, 1'b0, 1'b0, ST_SHORT, 1'b1);
    // zero length: the byte closes the frame unparsed, status stays ok
    add_row(8'h00, 8'd0, 1'b0, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    // bad sync
    add_row(8'h12, 8'd3, 1'b1, RT_DROP, 1'b0, 1'b0, ST_BAD_SYNC, 1'b0);
    add_row(8'hFF, 8'd3, 1'b1, RT_DROP, 1'b0, 1'b0, ST_BAD_SYNC, 1'b0);
    add_row(TAG_A, 8'd3, 1'b1, RT_DROP, 1'b0, 1'b0, ST_BAD_SYNC, 1'b1);
    // null packet
    add_row(SYNC_BYTE, 8'd3, 1'b1, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'h80, 8'd3, 1'b1, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'h00, 8'd3, 1'b1, RT_DROP, 1'b0, 1'b0, ST_NULL, 1'b1);
    // bad tag
    add_row(SYNC_BYTE, 8'd3, 1'b1, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'h01, 8'd3, 1'b1, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'hAA, 8'd3, 1'b1, RT_DROP, 1'b0, 1'b0, ST_BAD_TAG, 1'b1);
    // consumer report to the cache, then a type byte with too few bytes left
    add_row(SYNC_BYTE, 8'd9, 1'b1, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'h7F, 8'd9, 1'b1, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(TAG_D, 8'd9, 1'b1, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(TYPE_CONSUMER, 8'd9, 1'b1, RT_CONS_CACHE, 1'b1, 1'b0, ST_OK, 1'b0);
    add_row(8'h00, 8'd9, 1'b0, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'hFF, 8'd9, 1'b0, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'h55, 8'd9, 1'b0, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'hAA, 8'd9, 1'b0, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(TYPE_KBD, 8'd9, 1'b1, RT_DROP, 1'b0, 1'b0, ST_TRUNCATED, 1'b1);
    // tail report takes the rest of the frame
    add_row(SYNC_BYTE, 8'd6, 1'b0, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'h00, 8'd6, 1'b0, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(TAG_B, 8'd6, 1'b0, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(TYPE_TAIL_A, 8'd6, 1'b1, RT_TAIL, 1'b1, 1'b0, ST_OK, 1'b0);
    add_row(8'h11, 8'd6, 1'b0, RT_DROP, 1'b0, 1'b0, ST_OK, 1'b0);
    add_row(8'hFF, 8'd6, 1'b1, RT_TAIL, 1'b0, 1'b1, ST_OK, 1'b1);

    foreach (rows[i]) send_byte(rows[i].b, rows[i].flen, rows[i].pin);

    // random frames under both panel settings, last phase without idling
    write_panel(1'b1);
    random_frames(600);
    write_panel(1'b0);
    random_frames(600);
    write_panel(1'b1);
    quiet = 1'b1;
    random_frames(500);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && routed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/krfs_pkg.sv
rtl/krfs_parser.sv
rtl/keyboard_report_frame_splitter.sv
rtl/kbrfs_checker.sv
tb/testbench.sv
